>>> design/dbd_pkg.sv
// Shared types, codes and the barcode prefix compare for the dual barcode demultiplexer.
// Used by dbd_front, dbd_back and dual_barcode_demultiplexer.
`default_nettype none
package dbd_pkg;

   localparam int BASE_BITS   = 3;
   localparam int FIELD_BASES = 16;
   localparam int CODE_W      = BASE_BITS * FIELD_BASES;
   localparam int LEN_W       = 5;

   // Function codes of an input beat.
   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_LOADED  = 2'd0;
   localparam logic [1:0] ST_MATCH   = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;
   localparam logic [1:0] ST_REJECT  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_SEED_LENGTH  = 1'b0;
   localparam logic CSR_KEEP_BARCODE = 1'b1;

   typedef struct packed {
      logic              func;
      logic [3:0]        entry_index;
      logic [CODE_W-1:0] fwd_code;
      logic [LEN_W-1:0]  fwd_len;
      logic [CODE_W-1:0] rev_code;
      logic [LEN_W-1:0]  rev_len;
      logic [CODE_W-1:0] first_read_bases;
      logic [LEN_W-1:0]  first_read_count;
      logic [CODE_W-1:0] second_read_bases;
      logic [LEN_W-1:0]  second_read_count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [3:0]       sample_slot;
      logic             swapped;
      logic [LEN_W-1:0] trim_first;
      logic [LEN_W-1:0] trim_second;
      logic             last;
   } rsp_type;

   // One queued command: the request plus the load check made at accept time.
   typedef struct packed {
      req_type req;
      logic    load_ok;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_DRAIN
   } back_state_type;

   // A read hits a barcode of len bases when it has at least len bases and
   // its leading len base codes equal the barcode's, all codes compared literally.
   function automatic logic prefix_hit(logic [CODE_W-1:0] bases, logic [LEN_W-1:0] count,
                                       logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
      logic [CODE_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < FIELD_BASES; b++) begin
         if (LEN_W'(b) < len) begin
            mask[b*BASE_BITS +: BASE_BITS] = '1;
         end
      end
      return (count >= len) && (((bases ^ code) & mask) == '0);
   endfunction

endpackage
`default_nettype wire

>>> design/dbd_front.sv
// Front end: accepts input beats, runs the load length check and queues commands.
// Depends on dbd_pkg.
`default_nettype none
module dbd_front #(
   parameter int NUM_SAMPLES       = 16,
   parameter int MAX_BARCODE_BASES = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire dbd_pkg::req_type            req_data,
   input  wire logic [dbd_pkg::LEN_W-1:0]   seed_length,
   output logic                             cmd_valid,
   output dbd_pkg::cmd_type                 cmd,
   input  wire logic                        cmd_pop
);
   import dbd_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       load_ok;

   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   assign load_ok = (32'(req_data.entry_index) < NUM_SAMPLES) &&
                    (req_data.fwd_len >= seed_length) &&
                    (req_data.rev_len >= seed_length) &&
                    (32'(req_data.fwd_len) <= MAX_BARCODE_BASES) &&
                    (32'(req_data.rev_len) <= MAX_BARCODE_BASES);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{req: req_data, load_ok: load_ok};
      end
   end

endmodule
`default_nettype wire

>>> design/dbd_back.sv
// Back end: holds the sample table, compares all slots at once and drains
// the hits one result beat per cycle. Depends on dbd_pkg.
`default_nettype none
module dbd_back #(
   parameter int NUM_SAMPLES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire dbd_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   input  wire logic             keep_barcode,
   output logic                  rsp_strobe,
   output dbd_pkg::rsp_type      rsp_data
);
   import dbd_pkg::*;

   localparam int SLOT_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

   logic [CODE_W-1:0]    fwd_code_ff [NUM_SAMPLES];
   logic [LEN_W-1:0]     fwd_len_ff  [NUM_SAMPLES];
   logic [CODE_W-1:0]    rev_code_ff [NUM_SAMPLES];
   logic [LEN_W-1:0]     rev_len_ff  [NUM_SAMPLES];
   logic [NUM_SAMPLES-1:0] valid_ff, valid_in;

   back_state_type         state_ff, state_in;
   logic [NUM_SAMPLES-1:0] hit_fwd_ff, hit_fwd_in;
   logic [NUM_SAMPLES-1:0] hit_swp_ff, hit_swp_in;
   logic [NUM_SAMPLES-1:0] hit_fwd, hit_swp;
   logic [NUM_SAMPLES-1:0] pick_vec, pick_onehot, pick_rest;
   logic [SLOT_W-1:0]      sel;
   logic                   use_swp;
   logic                   table_we;
   logic [SLOT_W-1:0]      wr_slot;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]       len_a, len_b;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign wr_slot    = SLOT_W'(cmd.req.entry_index);

   // Every slot in both orientations is compared against the head command at once.
   always_comb begin
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         hit_fwd[i] = valid_ff[i] &&
            prefix_hit(cmd.req.first_read_bases, cmd.req.first_read_count,
                       fwd_code_ff[i], fwd_len_ff[i]) &&
            prefix_hit(cmd.req.second_read_bases, cmd.req.second_read_count,
                       rev_code_ff[i], rev_len_ff[i]);
         hit_swp[i] = valid_ff[i] &&
            prefix_hit(cmd.req.first_read_bases, cmd.req.first_read_count,
                       rev_code_ff[i], rev_len_ff[i]) &&
            prefix_hit(cmd.req.second_read_bases, cmd.req.second_read_count,
                       fwd_code_ff[i], fwd_len_ff[i]);
      end
   end

   // Forward hits drain first, lowest slot first.
   always_comb begin
      use_swp     = (hit_fwd_ff == '0);
      pick_vec    = use_swp ? hit_swp_ff : hit_fwd_ff;
      pick_onehot = pick_vec & (~pick_vec + 1'b1);
      pick_rest   = pick_vec & ~pick_onehot;
      sel         = '0;
      for (int i = NUM_SAMPLES - 1; i >= 0; i--) begin
         if (pick_vec[i]) begin
            sel = SLOT_W'(i);
         end
      end
      len_a = use_swp ? rev_len_ff[sel] : fwd_len_ff[sel];
      len_b = use_swp ? fwd_len_ff[sel] : rev_len_ff[sel];
   end

   always_comb begin
      state_in      = state_ff;
      hit_fwd_in    = hit_fwd_ff;
      hit_swp_in    = hit_swp_ff;
      valid_in      = valid_ff;
      table_we      = 1'b0;
      cmd_pop       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '{status: ST_NOMATCH, sample_slot: 4'd0, swapped: 1'b0,
                        trim_first: '0, trim_second: '0, last: 1'b1};
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.req.func == FUNC_LOAD) begin
                  rsp_strobe_in = 1'b1;
                  if (cmd.load_ok) begin
                     table_we           = 1'b1;
                     valid_in[wr_slot]  = 1'b1;
                     rsp_data_in.status = ST_LOADED;
                  end else begin
                     rsp_data_in.status = ST_REJECT;
                  end
               end else if ((hit_fwd != '0) || (hit_swp != '0)) begin
                  hit_fwd_in = hit_fwd;
                  hit_swp_in = hit_swp;
                  state_in   = BK_DRAIN;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         BK_DRAIN: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in.status      = ST_MATCH;
            rsp_data_in.sample_slot = 4'(sel);
            rsp_data_in.swapped     = use_swp;
            rsp_data_in.trim_first  = keep_barcode ? '0 : len_a;
            rsp_data_in.trim_second = keep_barcode ? '0 : len_b;
            if (use_swp) begin
               hit_swp_in = pick_rest;
            end else begin
               hit_fwd_in = pick_rest;
            end
            rsp_data_in.last = use_swp ? (pick_rest == '0)
                                       : ((pick_rest == '0) && (hit_swp_ff == '0));
            if (rsp_data_in.last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_fwd_ff  <= hit_fwd_in;
      hit_swp_ff  <= hit_swp_in;
      rsp_data_ff <= rsp_data_in;
      if (table_we) begin
         fwd_code_ff[wr_slot] <= cmd.req.fwd_code;
         fwd_len_ff[wr_slot]  <= cmd.req.fwd_len;
         rev_code_ff[wr_slot] <= cmd.req.rev_code;
         rev_len_ff[wr_slot]  <= cmd.req.rev_len;
      end
   end

endmodule
`default_nettype wire

>>> design/dual_barcode_demultiplexer.sv
// Top level of the paired-end dual barcode demultiplexer: configuration
// registers, front queue and back-end matcher. Depends on dbd_pkg, dbd_front, dbd_back.
`default_nettype none
// Usage:
// A command beat (req_data) is taken on a clock edge with start high and busy low.
// A load beat writes one sample slot and yields one result beat (loaded or
// rejected). A classify beat yields one result beat per hit, forward
// orientation first and then swapped, each in ascending slot order, or one
// no-match beat; the final beat of a command carries last.
// Results appear on rsp_data for exactly one cycle, flagged by rsp_strobe; the
// receiver cannot stall, so no result is ever held back.
// A command waits in the queue until the back end pops it; a classify with hits
// first registers its hit vectors and enters the drain state before its first beat.
// The back end pops a command only in its idle state, after the previous command's
// last beat; all slots are compared at once, and the hit drain, one result beat per
// cycle, sets the rate. A two-entry command queue lets new beats in while the back
// end drains; busy is high while it is full.
// Registers: index 0 seed_length, index 1 keep_barcode, written through the csr
// channel (csr_ready is always high). The user must write them only while the block
// is idle; the block itself does not enforce this.
// Reset empties the queue, clears every slot and sets seed_length 5, keep_barcode 0.
module dual_barcode_demultiplexer #(
   parameter int NUM_SAMPLES       = 16,
   parameter int MAX_BARCODE_BASES = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire dbd_pkg::req_type           req_data,
   output logic                            rsp_strobe,
   output dbd_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [dbd_pkg::LEN_W-1:0]  csr_wdata
);
   import dbd_pkg::*;

   logic [LEN_W-1:0] seed_length_ff, seed_length_in;
   logic             keep_barcode_ff, keep_barcode_in;
   logic             cmd_valid;
   logic             cmd_pop;
   cmd_type          cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      seed_length_in  = seed_length_ff;
      keep_barcode_in = keep_barcode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEED_LENGTH:  seed_length_in  = csr_wdata;
            CSR_KEEP_BARCODE: keep_barcode_in = csr_wdata[0];
            default:          seed_length_in  = seed_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_length_ff  <= LEN_W'(5);
         keep_barcode_ff <= 1'b0;
      end else begin
         seed_length_ff  <= seed_length_in;
         keep_barcode_ff <= keep_barcode_in;
      end
   end

   dbd_front #(
      .NUM_SAMPLES       (NUM_SAMPLES),
      .MAX_BARCODE_BASES (MAX_BARCODE_BASES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .seed_length (seed_length_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   dbd_back #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .keep_barcode (keep_barcode_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire

>>> tb/tb_dual_barcode_demultiplexer.sv
// Self-checking testbench for dual_barcode_demultiplexer: directed and random load and
// classify beats, checked against an in-bench mirror of the sample table and its scan.
// Depends on dbd_pkg and the dual_barcode_demultiplexer RTL.
`default_nettype none
module tb_dual_barcode_demultiplexer;
   timeunit 1ns;
   timeprecision 1ps;
   import dbd_pkg::*;

   localparam int NUM_SLOTS   = 16;
   localparam int MAX_BASES   = 16;
   localparam int MAX_BEATS   = 32;
   localparam int STALL_LIMIT = 4000;
   localparam logic [CODE_W-1:0] ALL_ONES = '1;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [LEN_W-1:0] csr_wdata;

   // Mirror of the sample table and the two registers.
   logic              tbl_valid   [NUM_SLOTS];
   logic [CODE_W-1:0] tbl_fwd     [NUM_SLOTS];
   logic [LEN_W-1:0]  tbl_fwd_len [NUM_SLOTS];
   logic [CODE_W-1:0] tbl_rev     [NUM_SLOTS];
   logic [LEN_W-1:0]  tbl_rev_len [NUM_SLOTS];
   logic [LEN_W-1:0]  cfg_seed;
   logic              cfg_keep;

   rsp_type pending_beats[$];
   rsp_type want;
   int      errors;
   int      idle_cycles;
   int      n_loads;
   int      n_rejects;
   int      n_classify;
   int      n_match_beats;
   int      n_nomatch;
   int      widest;
   bit      gap_free;

   dual_barcode_demultiplexer #(
      .NUM_SAMPLES      (NUM_SLOTS),
      .MAX_BARCODE_BASES(MAX_BASES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [CODE_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [63:0] m;
      m = (64'd1 << (BASE_BITS * len)) - 64'd1;
      return m[CODE_W-1:0];
   endfunction

   function automatic bit barcode_hit(input logic [CODE_W-1:0] bases,
                                      input logic [LEN_W-1:0]  count,
                                      input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0]  len);
      return (count >= len) && (((bases ^ code) & prefix_mask(len)) == '0);
   endfunction

   // Applies one accepted beat to the table mirror and queues the result beats it causes.
   function automatic void predict_demux_beats(input req_type r);
      rsp_type           beat;
      rsp_type           burst[$];
      logic              ok;
      logic [CODE_W-1:0] code1;
      logic [CODE_W-1:0] code2;
      logic [LEN_W-1:0]  len1;
      logic [LEN_W-1:0]  len2;
      if (r.func == FUNC_LOAD) begin
         ok = (r.fwd_len >= cfg_seed) && (r.rev_len >= cfg_seed) &&
              (r.fwd_len <= MAX_BASES) && (r.rev_len <= MAX_BASES);
         if (ok) begin
            tbl_valid[r.entry_index]   = 1'b1;
            tbl_fwd[r.entry_index]     = r.fwd_code;
            tbl_fwd_len[r.entry_index] = r.fwd_len;
            tbl_rev[r.entry_index]     = r.rev_code;
            tbl_rev_len[r.entry_index] = r.rev_len;
         end
         beat = '0;
         beat.status = ok ? ST_LOADED : ST_REJECT;
         burst.push_back(beat);
         n_loads++;
         if (!ok) n_rejects++;
      end else begin
         n_classify++;
         for (int pass = 0; pass < 2; pass++) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (!tbl_valid[s]) continue;
               code1 = pass ? tbl_rev[s] : tbl_fwd[s];
               len1  = pass ? tbl_rev_len[s] : tbl_fwd_len[s];
               code2 = pass ? tbl_fwd[s] : tbl_rev[s];
               len2  = pass ? tbl_fwd_len[s] : tbl_rev_len[s];
               if (barcode_hit(r.first_read_bases, r.first_read_count, code1, len1) &&
                   barcode_hit(r.second_read_bases, r.second_read_count, code2, len2) &&
                   burst.size() < MAX_BEATS) begin
                  beat = '0;
                  beat.status      = ST_MATCH;
                  beat.sample_slot = 4'(s);
                  beat.swapped     = 1'(pass);
                  beat.trim_first  = cfg_keep ? '0 : len1;
                  beat.trim_second = cfg_keep ? '0 : len2;
                  burst.push_back(beat);
               end
            end
         end
         n_match_beats += burst.size();
         if (burst.size() == 0) begin
            beat = '0;
            beat.status = ST_NOMATCH;
            burst.push_back(beat);
            n_nomatch++;
         end
         if (burst.size() > widest) widest = burst.size();
      end
      beat = burst.pop_back();
      beat.last = 1'b1;
      burst.push_back(beat);
      foreach (burst[k]) pending_beats.push_back(burst[k]);
   endfunction

   function automatic logic [CODE_W-1:0] random_bases();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[CODE_W-1:0];
   endfunction

   function automatic req_type load_cmd(input logic [3:0] slot,
                                        input logic [CODE_W-1:0] fcode,
                                        input logic [LEN_W-1:0] flen,
                                        input logic [CODE_W-1:0] rcode,
                                        input logic [LEN_W-1:0] rlen);
      req_type r;
      r.func              = FUNC_LOAD;
      r.entry_index       = slot;
      r.fwd_code          = fcode;
      r.fwd_len           = flen;
      r.rev_code          = rcode;
      r.rev_len           = rlen;
      r.first_read_bases  = random_bases();
      r.first_read_count  = 5'($urandom);
      r.second_read_bases = random_bases();
      r.second_read_count = 5'($urandom);
      return r;
   endfunction

   function automatic req_type classify_cmd(input logic [CODE_W-1:0] b1,
                                            input logic [LEN_W-1:0] c1,
                                            input logic [CODE_W-1:0] b2,
                                            input logic [LEN_W-1:0] c2);
      req_type r;
      r.func              = FUNC_CLASSIFY;
      r.entry_index       = 4'($urandom);
      r.fwd_code          = random_bases();
      r.fwd_len           = 5'($urandom);
      r.rev_code          = random_bases();
      r.rev_len           = 5'($urandom);
      r.first_read_bases  = b1;
      r.first_read_count  = c1;
      r.second_read_bases = b2;
      r.second_read_count = c2;
      return r;
   endfunction

   // A read that begins with the given barcode, random bases after it.
   function automatic logic [CODE_W-1:0] read_with_prefix(input logic [CODE_W-1:0] code,
                                                          input logic [LEN_W-1:0] len);
      return (code & prefix_mask(len)) | (random_bases() & ~prefix_mask(len));
   endfunction

   function automatic logic [LEN_W-1:0] read_count_for(input logic [LEN_W-1:0] len);
      if ($urandom_range(9) == 0) return 5'($urandom_range(31, len));
      return 5'($urandom_range(MAX_BASES, len));
   endfunction

   // Mostly short barcodes so that several slots can hit the same read pair.
   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(1) == 0) return 5'($urandom_range(MAX_BASES, cfg_seed));
      return 5'($urandom_range((cfg_seed + 2 > MAX_BASES) ? MAX_BASES : cfg_seed + 2,
                               cfg_seed));
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_cmd(input req_type r);
      while (!gap_free && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_demux_beats(r);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [LEN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SEED_LENGTH) cfg_seed = value;
      else cfg_keep = value[0];
      @(negedge clock);
   endtask

   task automatic set_config(input logic [LEN_W-1:0] seed, input logic keep);
      wait_idle();
      write_csr(CSR_SEED_LENGTH, seed);
      write_csr(CSR_KEEP_BARCODE, {4'($urandom), keep});
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      req_type           r;
      int                s;
      int                b;
      bit                swp;
      logic [LEN_W-1:0]  fl;
      logic [LEN_W-1:0]  rl;
      logic [CODE_W-1:0] c1;
      logic [CODE_W-1:0] c2;
      logic [LEN_W-1:0]  l1;
      logic [LEN_W-1:0]  l2;
      if ($urandom_range(99) < 30) begin
         if (cfg_seed <= MAX_BASES && $urandom_range(99) < 80) begin
            fl = pick_len();
            rl = pick_len();
         end else begin
            fl = 5'($urandom);
            rl = 5'($urandom);
         end
         r = load_cmd(4'($urandom), random_bases(), fl, random_bases(), rl);
      end else begin
         s = $urandom_range(NUM_SLOTS - 1);
         for (int k = 0; k < NUM_SLOTS && !tbl_valid[s]; k++) s = (s + 1) % NUM_SLOTS;
         if (tbl_valid[s] && $urandom_range(99) < 75) begin
            swp = 1'($urandom);
            c1 = swp ? tbl_rev[s] : tbl_fwd[s];
            l1 = swp ? tbl_rev_len[s] : tbl_fwd_len[s];
            c2 = swp ? tbl_fwd[s] : tbl_rev[s];
            l2 = swp ? tbl_fwd_len[s] : tbl_rev_len[s];
            r = classify_cmd(read_with_prefix(c1, l1), read_count_for(l1),
                             read_with_prefix(c2, l2), read_count_for(l2));
            // Near misses: a read one base too short, or one base of the first read's barcode prefix changed.
            case ($urandom_range(9))
               0: if (l1 != 0) r.first_read_count = l1 - 5'd1;
               1: if (l2 != 0) r.second_read_count = l2 - 5'd1;
               2: if (l1 != 0) begin
                  b = $urandom_range(l1 - 1);
                  r.first_read_bases[b*BASE_BITS +: BASE_BITS] =
                     r.first_read_bases[b*BASE_BITS +: BASE_BITS] ^ 3'($urandom_range(7, 1));
               end
               default: ;
            endcase
         end else begin
            r = classify_cmd(random_bases(), 5'($urandom), random_bases(), 5'($urandom));
         end
      end
      send_cmd(r);
   endtask

   task automatic test_empty_table();
      send_cmd(classify_cmd(random_bases(), 5'd16, random_bases(), 5'd16));
   endtask

   task automatic test_load_length_check();
      send_cmd(load_cmd(4'd1, random_bases(), 5'd4, random_bases(), 5'd5));
      send_cmd(load_cmd(4'd2, random_bases(), 5'd5, random_bases(), 5'd4));
      send_cmd(load_cmd(4'd4, random_bases(), 5'd17, random_bases(), 5'd5));
      send_cmd(load_cmd(4'd5, random_bases(), 5'd16, random_bases(), 5'd31));
      send_cmd(load_cmd(4'd6, '0, 5'd0, '0, 5'd0));
      send_cmd(load_cmd(4'd0, ALL_ONES, 5'd16, '0, 5'd5));
      send_cmd(load_cmd(4'd15, '0, 5'd5, ALL_ONES, 5'd16));
   endtask

   // Slot 15 holds the barcodes of slot 0 the other way round.
   task automatic test_orientation_match();
      send_cmd(classify_cmd(ALL_ONES, 5'd16, '0, 5'd31));
      send_cmd(classify_cmd(ALL_ONES, 5'd15, '0, 5'd5));
      send_cmd(classify_cmd('0, 5'd5, ALL_ONES, 5'd16));
   endtask

   task automatic test_keep_barcode();
      set_config(5'd5, 1'b1);
      send_cmd(classify_cmd(ALL_ONES, 5'd16, '0, 5'd16));
      set_config(5'd5, 1'b0);
   endtask

   task automatic test_reload_slot();
      send_cmd(load_cmd(4'd0, {16{3'd2}}, 5'd6, {16{3'd4}}, 5'd7));
      send_cmd(classify_cmd(ALL_ONES, 5'd16, '0, 5'd16));
      send_cmd(classify_cmd({16{3'd2}}, 5'd6, {16{3'd4}}, 5'd7));
   endtask

   task automatic test_zero_length_barcode();
      set_config(5'd0, 1'b0);
      send_cmd(load_cmd(4'd3, random_bases(), 5'd0, random_bases(), 5'd0));
      send_cmd(classify_cmd(random_bases(), 5'd0, random_bases(), 5'd0));
      // Overwrite the catch-all slot so later traffic still sees no-match results.
      send_cmd(load_cmd(4'd3, random_bases(), 5'd16, random_bases(), 5'd16));
   endtask

   task automatic test_random_traffic();
      logic [LEN_W-1:0] seeds [6];
      seeds = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'($urandom_range(16, 1))};
      for (int p = 0; p < 6; p++) begin
         gap_free = (p == 1);
         set_config(seeds[p], 1'(p));
         repeat (36) random_item();
      end
      gap_free = 1'b0;
   endtask

   // Every slot gets the same one-base barcode, so a matching pair drains 32 beats.
   task automatic test_dense_table();
      logic [2:0]        base;
      logic [CODE_W-1:0] fcode;
      logic [CODE_W-1:0] rcode;
      logic [CODE_W-1:0] b1;
      logic [CODE_W-1:0] b2;
      gap_free = 1'b1;
      set_config(5'd1, 1'($urandom));
      base = 3'($urandom);
      for (int s = 0; s < NUM_SLOTS; s++) begin
         fcode = random_bases();
         rcode = random_bases();
         fcode[2:0] = base;
         rcode[2:0] = base;
         send_cmd(load_cmd(4'(s), fcode, 5'd1, rcode, 5'd1));
      end
      repeat (4) begin
         b1 = random_bases();
         b2 = random_bases();
         b1[2:0] = base;
         b2[2:0] = base;
         send_cmd(classify_cmd(b1, 5'($urandom_range(31, 1)), b2, 5'($urandom_range(31, 1))));
      end
      send_cmd(classify_cmd(b1, 5'd16, b2, 5'd0));
      gap_free = 1'b0;
   endtask

   function automatic void compare_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %0d slot %0d",
                     $time, rsp_data.status, rsp_data.sample_slot);
            errors++;
         end else begin
            want = pending_beats.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("sample_slot", want.sample_slot, rsp_data.sample_slot);
            compare_field("swapped", want.swapped, rsp_data.swapped);
            compare_field("trim_first", want.trim_first, rsp_data.trim_first);
            compare_field("trim_second", want.trim_second, rsp_data.trim_second);
            compare_field("last", want.last, rsp_data.last);
         end
      end
   end

   // Ends the run when no beat of any kind has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("tb_dual_barcode_demultiplexer: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = 1'b0;
      csr_wdata     = '0;
      cfg_seed      = 5'd5;
      cfg_keep      = 1'b0;
      errors        = 0;
      idle_cycles   = 0;
      n_loads       = 0;
      n_rejects     = 0;
      n_classify    = 0;
      n_match_beats = 0;
      n_nomatch     = 0;
      widest        = 0;
      gap_free      = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) tbl_valid[s] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_load_length_check();
      test_orientation_match();
      test_keep_barcode();
      test_reload_slot();
      test_zero_length_barcode();
      test_random_traffic();
      test_dense_table();

      wait_idle();
      repeat (12) @(negedge clock);
      if (pending_beats.size() != 0) begin
         $display("%0t: %0d result beats expected but never seen", $time,
                  pending_beats.size());
         errors++;
      end
      $display("Ran %0d loads (%0d rejected) and %0d classify beats across seed lengths 0 to 31.",
               n_loads, n_rejects, n_classify);
      $display("Saw %0d match beats, %0d no-match results, longest burst %0d beats.",
               n_match_beats, n_nomatch, widest);
      if (errors == 0) $display("tb_dual_barcode_demultiplexer: PASS");
      else $display("tb_dual_barcode_demultiplexer: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
